// ===== rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

  // Screen geometry.
  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int CELLS = COLS * ROWS;

  // Field widths.
  localparam int OP_W   = 3;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = CHAR_W + ATTR_W;

  // Screen store addressing; the sweep counter can also hold CELLS itself.
  localparam int ADDR_W = $clog2(CELLS);
  localparam int PTR_W  = $clog2(CELLS + 1);

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE     = 3'd0,
    OP_PUT       = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_CLEAR_ROW = 3'd3,
    OP_READ      = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  target_col;
    logic [ROW_W-1:0]  target_row;
  } cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
  } rsp_t;

  // Linear cell address of a row and column.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(row) * ADDR_W'(COLS);
    return base + ADDR_W'(col);
  endfunction

endpackage

// ===== rtl/text_console_writer.sv =====
`timescale 1ns / 1ps

// Text console with a screen store of ROWS x COLS cells (character and attribute).
// Commands arrive on the cmd channel (valid/ready); each produces exactly one
// word on the rsp channel with the read cell, the cursor after the command and
// a scroll flag. cfg_we/cfg_data set the attribute used for written and blanked
// cells; write it only while the console is idle.
// The two-port screen memory takes one write and one read per cycle.
// Work per command:
//   write at cursor, put, read, clear row out of range: no sweep.
//   clear row: the COLS cells of the row are blanked.
//   clear screen: all ROWS*COLS cells are blanked.
//   a write or newline that scrolls: the copy moves one cell per cycle
//   up one row, then the last row is blanked one cell per cycle.
// The next command is accepted while a finished response still waits in the
// output register; if the receiver keeps stalling, the following command stops
// in its final cycle until that register frees.
// Reset puts the cursor at row 0, column 0 and the attribute at 7. The screen
// store is not cleared; read only cells that were written since reset.
module text_console_writer (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  tcw_pkg::cmd_t            cmd,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output tcw_pkg::rsp_t            rsp,
  input  logic                     cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_data
);

  // Screen store.
  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];
  logic                       mem_we;
  logic [tcw_pkg::ADDR_W-1:0] mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [tcw_pkg::ADDR_W-1:0] mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] rd_data;

  tcw_pkg::state_t            state;
  tcw_pkg::state_t            state_next;
  logic [tcw_pkg::ATTR_W-1:0] color_attr;
  logic [tcw_pkg::COL_W-1:0]  cur_x;
  logic [tcw_pkg::ROW_W-1:0]  cur_y;
  logic [tcw_pkg::PTR_W-1:0]  ptr;
  logic [tcw_pkg::PTR_W-1:0]  clr_end;
  logic                       res_read;
  logic                       res_scrolled;

  logic                       accept;
  logic                       in_range;
  logic                       row_ok;
  logic                       is_newline;
  logic                       at_last_col;
  logic                       at_last_row;
  logic                       need_scroll;
  logic                       rsp_free;
  logic [tcw_pkg::ADDR_W-1:0] tgt_addr;
  logic [tcw_pkg::ADDR_W-1:0] cur_addr;
  logic [tcw_pkg::ADDR_W-1:0] row_base;
  logic [tcw_pkg::ADDR_W-1:0] copy_dst;

  // Command decode.
  assign accept      = cmd_valid && cmd_ready;
  assign rsp_free    = !rsp_valid || rsp_ready;
  assign row_ok      = cmd.target_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS);
  assign in_range    = row_ok && (cmd.target_col < tcw_pkg::COL_W'(tcw_pkg::COLS));
  assign is_newline  = cmd.char_code == tcw_pkg::NEWLINE_CHAR;
  assign at_last_col = cur_x == tcw_pkg::COL_W'(tcw_pkg::COLS - 1);
  assign at_last_row = cur_y == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
  assign need_scroll = (cmd.opcode == tcw_pkg::OP_WRITE) && at_last_row &&
                       (is_newline || at_last_col);
  assign tgt_addr    = tcw_pkg::cell_addr(cmd.target_row, cmd.target_col);
  assign cur_addr    = tcw_pkg::cell_addr(cur_y, cur_x);
  assign row_base    = tcw_pkg::cell_addr(cmd.target_row, '0);
  assign copy_dst    = ptr[tcw_pkg::ADDR_W-1:0] - tcw_pkg::ADDR_W'(tcw_pkg::COLS + 1);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd.opcode)
            tcw_pkg::OP_WRITE:     state_next = need_scroll ? tcw_pkg::ST_COPY
                                                            : tcw_pkg::ST_DONE;
            tcw_pkg::OP_CLEAR:     state_next = tcw_pkg::ST_CLEAR;
            tcw_pkg::OP_CLEAR_ROW: state_next = row_ok ? tcw_pkg::ST_CLEAR
                                                       : tcw_pkg::ST_DONE;
            default:               state_next = tcw_pkg::ST_DONE;
          endcase
        end
      end
      tcw_pkg::ST_COPY: begin
        if (ptr == tcw_pkg::PTR_W'(tcw_pkg::CELLS)) state_next = tcw_pkg::ST_CLEAR;
      end
      tcw_pkg::ST_CLEAR: begin
        if (ptr == clr_end - 1'b1) state_next = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_DONE: begin
        if (rsp_free) state_next = tcw_pkg::ST_IDLE;
      end
      default: state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  // Memory port control and handshake outputs.
  always_comb begin
    cmd_ready = state == tcw_pkg::ST_IDLE;
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = {color_attr, cmd.char_code};
    mem_re    = 1'b0;
    mem_raddr = tgt_addr;
    case (state)
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd.opcode)
            tcw_pkg::OP_WRITE: begin
              mem_we = !is_newline;
            end
            tcw_pkg::OP_PUT: begin
              mem_we    = in_range;
              mem_waddr = tgt_addr;
            end
            tcw_pkg::OP_READ: begin
              mem_re = in_range;
            end
            default: begin
              mem_we = 1'b0;
            end
          endcase
        end
      end
      tcw_pkg::ST_COPY: begin
        // Read one row down; write back the cell read in the previous cycle.
        mem_re    = ptr != tcw_pkg::PTR_W'(tcw_pkg::CELLS);
        mem_raddr = ptr[tcw_pkg::ADDR_W-1:0];
        mem_we    = ptr != tcw_pkg::PTR_W'(tcw_pkg::COLS);
        mem_waddr = copy_dst;
        mem_wdata = rd_data;
      end
      tcw_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr[tcw_pkg::ADDR_W-1:0];
        mem_wdata = {color_attr, tcw_pkg::BLANK_CHAR};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Screen memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // Control state, cursor and attribute.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tcw_pkg::ST_IDLE;
      color_attr <= tcw_pkg::ATTR_RESET;
      cur_x      <= '0;
      cur_y      <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        color_attr <= cfg_data;
      end
      // Cursor moves only for writes at the cursor.
      if (accept && cmd.opcode == tcw_pkg::OP_WRITE) begin
        if (is_newline || at_last_col) begin
          cur_x <= '0;
          if (!at_last_row) cur_y <= cur_y + 1'b1;
        end else begin
          cur_x <= cur_x + 1'b1;
        end
      end
      if (state == tcw_pkg::ST_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Sweep counter, per-command result flags and output register.
  always_ff @(posedge clk) begin
    case (state)
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          res_read     <= (cmd.opcode == tcw_pkg::OP_READ) && in_range;
          res_scrolled <= need_scroll;
          if (cmd.opcode == tcw_pkg::OP_CLEAR) begin
            ptr     <= '0;
            clr_end <= tcw_pkg::PTR_W'(tcw_pkg::CELLS);
          end else if (cmd.opcode == tcw_pkg::OP_CLEAR_ROW) begin
            ptr     <= tcw_pkg::PTR_W'(row_base);
            clr_end <= tcw_pkg::PTR_W'(row_base) + tcw_pkg::PTR_W'(tcw_pkg::COLS);
          end else begin
            ptr <= tcw_pkg::PTR_W'(tcw_pkg::COLS);
          end
        end
      end
      tcw_pkg::ST_COPY: begin
        // After the copy, blank the last row.
        if (ptr == tcw_pkg::PTR_W'(tcw_pkg::CELLS)) begin
          ptr     <= tcw_pkg::PTR_W'((tcw_pkg::ROWS - 1) * tcw_pkg::COLS);
          clr_end <= tcw_pkg::PTR_W'(tcw_pkg::CELLS);
        end else begin
          ptr <= ptr + 1'b1;
        end
      end
      tcw_pkg::ST_CLEAR: begin
        ptr <= ptr + 1'b1;
      end
      tcw_pkg::ST_DONE: begin
        if (rsp_free) begin
          rsp.cell_char  <= res_read ? rd_data[tcw_pkg::CHAR_W-1:0] : '0;
          rsp.cell_attr  <= res_read ? rd_data[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
          rsp.cursor_col <= cur_x;
          rsp.cursor_row <= cur_y;
          rsp.scrolled   <= res_scrolled;
        end
      end
      default: begin
        ptr <= ptr;
      end
    endcase
  end

endmodule

// ===== rtl/tcw_checker.sv =====
`timescale 1ns / 1ps

module tcw_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       cmd_valid,
  input logic                       cmd_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input tcw_pkg::rsp_t              rsp
);

  // A stalled response word holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response word changed while stalled");

  // Accepting a command takes the console out of its ready state.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command accepted in back-to-back cycles");

  // A scroll always leaves the cursor at the start of the last row.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.scrolled |->
      rsp.cursor_col == '0 &&
      rsp.cursor_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1))
    else $error("scrolled response with cursor off the last row start");

  // The cursor stays on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |->
      rsp.cursor_col < tcw_pkg::COL_W'(tcw_pkg::COLS) &&
      rsp.cursor_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS))
    else $error("cursor outside the screen");

  // After reset the console is idle with nothing to deliver.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> cmd_ready && !rsp_valid)
    else $error("console not idle after reset");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// ===== test/tb_text_console_writer.sv =====
`timescale 1ns / 1ps

module tb_text_console_writer;

  // Opcodes that the console ignores.
  localparam logic [tcw_pkg::OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [tcw_pkg::OP_W-1:0] OP_RSVD_MID   = 3'd6;
  localparam logic [tcw_pkg::OP_W-1:0] OP_RSVD_LAST  = 3'd7;

  localparam int COL_MAX      = (1 << tcw_pkg::COL_W) - 1;
  localparam int ROW_MAX      = (1 << tcw_pkg::ROW_W) - 1;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 240;
  // A scrolling write is the slowest command.
  localparam int DRAIN_CYCLES = tcw_pkg::CELLS + 100;
  localparam int RUN_LIMIT_NS = 200_000_000;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    logic          typed;
    tcw_pkg::cmd_t c;
    tcw_pkg::rsp_t r;
  } dir_row_t;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          cmd_valid = 1'b0;
  logic          cmd_ready;
  tcw_pkg::cmd_t cmd       = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  tcw_pkg::rsp_t rsp;
  logic          cfg_we    = 1'b0;
  logic [tcw_pkg::ATTR_W-1:0] cfg_data = '0;

  // Shadow copy of the console: screen, cursor and attribute.
  logic [tcw_pkg::CELL_W-1:0] shadow_cells [tcw_pkg::CELLS];
  bit                         cell_known   [tcw_pkg::CELLS];
  logic [tcw_pkg::COL_W-1:0]  cur_col  = '0;
  logic [tcw_pkg::ROW_W-1:0]  cur_row  = '0;
  logic [tcw_pkg::ATTR_W-1:0] attr_now = tcw_pkg::ATTR_RESET;

  tcw_pkg::rsp_t pending_rsp [$];
  dir_row_t      dir_tab [$];
  int            n_bad     = 0;
  int            n_rsp     = 0;
  int            n_cmds    = 0;
  int            n_scrolls = 0;
  int            n_attr    = 0;

  logic [7:0] rdy_pat = 8'hFF;
  logic [2:0] rdy_ph  = '0;
  int         rdy_rep = 0;

  text_console_writer uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Screen update helpers for the shadow copy.
  function automatic void fill_cell(int idx, logic [tcw_pkg::CHAR_W-1:0] ch);
    shadow_cells[idx] = {attr_now, ch};
    cell_known[idx]   = 1'b1;
  endfunction

  function automatic void blank_line(int row);
    int x;
    for (x = 0; x < tcw_pkg::COLS; x++) fill_cell(row * tcw_pkg::COLS + x, tcw_pkg::BLANK_CHAR);
  endfunction

  // Moves the cursor to the start of the next line, scrolling at the bottom.
  function automatic logic next_line();
    int i;
    cur_col = '0;
    if (int'(cur_row) + 1 >= tcw_pkg::ROWS) begin
      for (i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLS; i++) begin
        shadow_cells[i] = shadow_cells[i + tcw_pkg::COLS];
        cell_known[i]   = cell_known[i + tcw_pkg::COLS];
      end
      blank_line(tcw_pkg::ROWS - 1);
      n_scrolls++;
      return 1'b1;
    end
    cur_row = cur_row + 1'b1;
    return 1'b0;
  endfunction

  // Applies one command to the shadow console and returns the response word.
  function automatic tcw_pkg::rsp_t console_step(tcw_pkg::cmd_t c);
    tcw_pkg::rsp_t r;
    logic hit;
    int   idx;
    int   y;
    r   = '0;
    hit = (int'(c.target_col) < tcw_pkg::COLS) && (int'(c.target_row) < tcw_pkg::ROWS);
    idx = int'(c.target_row) * tcw_pkg::COLS + int'(c.target_col);
    case (c.opcode)
      tcw_pkg::OP_WRITE: begin
        if (c.char_code == tcw_pkg::NEWLINE_CHAR) begin
          r.scrolled = next_line();
        end else begin
          fill_cell(int'(cur_row) * tcw_pkg::COLS + int'(cur_col), c.char_code);
          if (int'(cur_col) + 1 >= tcw_pkg::COLS) r.scrolled = next_line();
          else cur_col = cur_col + 1'b1;
        end
      end
      tcw_pkg::OP_PUT: begin
        if (hit) fill_cell(idx, c.char_code);
      end
      tcw_pkg::OP_CLEAR: begin
        for (y = 0; y < tcw_pkg::ROWS; y++) blank_line(y);
      end
      tcw_pkg::OP_CLEAR_ROW: begin
        if (int'(c.target_row) < tcw_pkg::ROWS) blank_line(int'(c.target_row));
      end
      tcw_pkg::OP_READ: begin
        if (hit) {r.cell_attr, r.cell_char} = shadow_cells[idx];
      end
      default: ;
    endcase
    r.cursor_col = cur_col;
    r.cursor_row = cur_row;
    return r;
  endfunction

  // Draws one random command. Reads only land on cells that hold a known value,
  // otherwise they are pushed off the screen.
  function automatic tcw_pkg::cmd_t pick_cmd();
    tcw_pkg::cmd_t c;
    int unsigned   sel;
    int unsigned   col;
    int unsigned   row;
    c.opcode     = tcw_pkg::OP_WRITE;
    c.char_code  = tcw_pkg::CHAR_W'($urandom);
    c.target_col = tcw_pkg::COL_W'($urandom);
    c.target_row = tcw_pkg::ROW_W'($urandom);
    col = $urandom_range(0, tcw_pkg::COLS - 1);
    row = $urandom_range(0, tcw_pkg::ROWS - 1);
    sel = $urandom_range(0, 99);
    if (sel < 38) begin
      c.opcode = tcw_pkg::OP_WRITE;
    end else if (sel < 45) begin
      c.opcode    = tcw_pkg::OP_WRITE;
      c.char_code = tcw_pkg::NEWLINE_CHAR;
    end else if (sel < 58) begin
      c.opcode = tcw_pkg::OP_PUT;
      if ($urandom_range(0, 9) != 0) begin
        c.target_col = tcw_pkg::COL_W'(col);
        c.target_row = tcw_pkg::ROW_W'(row);
      end
    end else if (sel < 82) begin
      c.opcode = tcw_pkg::OP_READ;
      // About half of the reads look at the cell left of the cursor, if not in column 0.
      if ($urandom_range(0, 1) == 1 && cur_col != 0) begin
        col = int'(cur_col) - 1;
        row = int'(cur_row);
      end
      if ($urandom_range(0, 9) == 0 || !cell_known[row * tcw_pkg::COLS + col])
        col = $urandom_range(tcw_pkg::COLS, COL_MAX);
      else if ($urandom_range(0, 19) == 0)
        row = $urandom_range(tcw_pkg::ROWS, ROW_MAX);
      c.target_col = tcw_pkg::COL_W'(col);
      c.target_row = tcw_pkg::ROW_W'(row);
    end else if (sel < 89) begin
      c.opcode = tcw_pkg::OP_CLEAR_ROW;
      if ($urandom_range(0, 7) != 0) c.target_row = tcw_pkg::ROW_W'(row);
    end else if (sel < 91) begin
      c.opcode = tcw_pkg::OP_CLEAR;
    end else begin
      c.opcode = tcw_pkg::OP_W'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
    end
    return c;
  endfunction

  task automatic flag_mismatch(string msg);
    if (n_bad < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    n_bad++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Adds one directed row; typed rows carry the response read off by hand.
  function automatic void tab_row(logic typed, logic [tcw_pkg::OP_W-1:0] op,
                                  logic [tcw_pkg::CHAR_W-1:0] ch,
                                  logic [tcw_pkg::COL_W-1:0] col,
                                  logic [tcw_pkg::ROW_W-1:0] row,
                                  logic [tcw_pkg::CHAR_W-1:0] e_ch,
                                  logic [tcw_pkg::ATTR_W-1:0] e_attr,
                                  logic [tcw_pkg::COL_W-1:0] e_col,
                                  logic [tcw_pkg::ROW_W-1:0] e_row);
    dir_row_t d;
    d.typed = typed;
    d.c     = {op, ch, col, row};
    d.r     = {e_ch, e_attr, e_col, e_row, 1'b0};
    dir_tab.push_back(d);
  endfunction

  // Offers one command word, waits for it to be taken and records the answer.
  task automatic send_word(tcw_pkg::cmd_t c, logic typed, tcw_pkg::rsp_t typed_rsp);
    tcw_pkg::rsp_t r;
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    r = console_step(c);
    pending_rsp.push_back(typed ? typed_rsp : r);
    n_cmds++;
  endtask

  task automatic wait_idle();
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic write_attr(logic [tcw_pkg::ATTR_W-1:0] v);
    cfg_data <= v;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    attr_now = v;
    n_attr++;
  endtask

  // Receiver: replays an 8-bit ready pattern a random number of times, then draws a new one.
  always @(posedge clk) begin
    rsp_ready <= rdy_pat[rdy_ph];
    rdy_ph    <= rdy_ph + 1'b1;
    if (rdy_ph == 3'd7) begin
      if (rdy_rep > 0) begin
        rdy_rep <= rdy_rep - 1;
      end else begin
        rdy_rep <= $urandom_range(0, 15);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: rdy_pat <= 8'hFF;
          4:          rdy_pat <= 8'h01;
          default:    rdy_pat <= 8'($urandom);
        endcase
      end
    end
  end

  // Response checker: every word taken is matched to the oldest expectation.
  always @(posedge clk) begin : rsp_check
    tcw_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        flag_mismatch($sformatf("response word %h with nothing expected", rsp));
      end else begin
        want = pending_rsp.pop_front();
        n_rsp++;
        check_field("cell_char", 32'(rsp.cell_char), 32'(want.cell_char));
        check_field("cell_attr", 32'(rsp.cell_attr), 32'(want.cell_attr));
        check_field("cursor_col", 32'(rsp.cursor_col), 32'(want.cursor_col));
        check_field("cursor_row", 32'(rsp.cursor_row), 32'(want.cursor_row));
        check_field("scrolled", 32'(rsp.scrolled), 32'(want.scrolled));
      end
    end
  end

  // Stimulus.
  initial begin : stim
    int          ph;
    int          left;
    int          burst;
    int          gap;
    int          k;
    logic [tcw_pkg::ATTR_W-1:0] attr_sel;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, run with the attribute left at its reset value.
    //      typed op                     char   col     row    e_char e_attr e_col e_row
    tab_row(1'b1, tcw_pkg::OP_READ,      8'h00, 7'd80,  5'd0,  8'h00, 8'h00, 7'd0, 5'd0);
    tab_row(1'b1, tcw_pkg::OP_WRITE,     8'h41, 7'd0,   5'd0,  8'h00, 8'h00, 7'd1, 5'd0);
    tab_row(1'b1, tcw_pkg::OP_READ,      8'h00, 7'd0,   5'd0,  8'h41, 8'h07, 7'd1, 5'd0);
    tab_row(1'b1, tcw_pkg::OP_PUT,       8'hFF, 7'd79,  5'd24, 8'h00, 8'h00, 7'd1, 5'd0);
    tab_row(1'b1, tcw_pkg::OP_READ,      8'h00, 7'd79,  5'd24, 8'hFF, 8'h07, 7'd1, 5'd0);
    tab_row(1'b1, tcw_pkg::OP_PUT,       8'h00, 7'd0,   5'd24, 8'h00, 8'h00, 7'd1, 5'd0);
    tab_row(1'b1, tcw_pkg::OP_READ,      8'hFF, 7'd0,   5'd24, 8'h00, 8'h07, 7'd1, 5'd0);
    // Targets off the screen change nothing and read back as zero.
    tab_row(1'b1, tcw_pkg::OP_PUT,       8'h55, 7'd127, 5'd31, 8'h00, 8'h00, 7'd1, 5'd0);
    tab_row(1'b1, tcw_pkg::OP_READ,      8'h00, 7'd0,   5'd25, 8'h00, 8'h00, 7'd1, 5'd0);
    tab_row(1'b1, tcw_pkg::OP_READ,      8'h00, 7'd127, 5'd31, 8'h00, 8'h00, 7'd1, 5'd0);
    tab_row(1'b1, tcw_pkg::OP_CLEAR_ROW, 8'h00, 7'd0,   5'd31, 8'h00, 8'h00, 7'd1, 5'd0);
    tab_row(1'b1, tcw_pkg::OP_READ,      8'h00, 7'd79,  5'd24, 8'hFF, 8'h07, 7'd1, 5'd0);
    tab_row(1'b1, tcw_pkg::OP_CLEAR_ROW, 8'h00, 7'd0,   5'd24, 8'h00, 8'h00, 7'd1, 5'd0);
    tab_row(1'b1, tcw_pkg::OP_READ,      8'h00, 7'd79,  5'd24, 8'h20, 8'h07, 7'd1, 5'd0);
    // Ignored opcodes answer with zero read fields.
    tab_row(1'b1, OP_RSVD_FIRST,         8'hFF, 7'd127, 5'd31, 8'h00, 8'h00, 7'd1, 5'd0);
    tab_row(1'b1, OP_RSVD_MID,           8'h0A, 7'd0,   5'd0,  8'h00, 8'h00, 7'd1, 5'd0);
    tab_row(1'b1, OP_RSVD_LAST,          8'h00, 7'd0,   5'd0,  8'h00, 8'h00, 7'd1, 5'd0);
    // Newline, then a screen clear that leaves the cursor in place.
    tab_row(1'b1, tcw_pkg::OP_WRITE,     8'h0A, 7'd0,   5'd0,  8'h00, 8'h00, 7'd0, 5'd1);
    tab_row(1'b1, tcw_pkg::OP_CLEAR,     8'hFF, 7'd127, 5'd31, 8'h00, 8'h00, 7'd0, 5'd1);
    tab_row(1'b1, tcw_pkg::OP_READ,      8'h00, 7'd0,   5'd0,  8'h20, 8'h07, 7'd0, 5'd1);
    tab_row(1'b0, tcw_pkg::OP_PUT,       8'h7F, 7'd40,  5'd12, 8'h00, 8'h00, 7'd0, 5'd0);
    tab_row(1'b0, tcw_pkg::OP_READ,      8'h00, 7'd40,  5'd12, 8'h00, 8'h00, 7'd0, 5'd0);
    tab_row(1'b0, tcw_pkg::OP_WRITE,     8'hFF, 7'd0,   5'd0,  8'h00, 8'h00, 7'd0, 5'd0);
    tab_row(1'b0, tcw_pkg::OP_WRITE,     8'h00, 7'd0,   5'd0,  8'h00, 8'h00, 7'd0, 5'd0);
    tab_row(1'b0, tcw_pkg::OP_READ,      8'h00, 7'd1,   5'd1,  8'h00, 8'h00, 7'd0, 5'd0);
    foreach (dir_tab[i]) send_word(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].r);
    cmd_valid <= 1'b0;

    // Random part in phases, each with its own attribute, written while idle.
    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      attr_sel = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : tcw_pkg::ATTR_W'($urandom);
      write_attr(attr_sel);
      left = PHASE_ITEMS;
      while (left > 0) begin
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        for (k = 0; k < burst && left > 0; k++) begin
          send_word(pick_cmd(), 1'b0, '0);
          left--;
        end
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          cmd_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      cmd_valid <= 1'b0;
    end

    // Let the last words drain and watch for anything extra.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d commands (%0d directed) under %0d attribute settings.",
             n_cmds, dir_tab.size(), n_attr);
    $display("Checked %0d response words; the screen scrolled %0d times.", n_rsp, n_scrolls);
    if (n_bad == 0) begin
      $display("tb_text_console_writer OK");
    end else begin
      $display("tb_text_console_writer NOT OK");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("tb_text_console_writer NOT OK");
    $finish;
  end

endmodule
